/* design/wnbs_pkg.sv */
// Shared constants, types and helpers for the wake/night brightness schedule.
`default_nettype none

package wnbs_pkg;

    localparam int WAKE_MIN_LEAD = 30;
    localparam int QUIET_RAMP    = 90;

    localparam int MIN_PER_DAY  = 24 * 60;
    localparam int SEC_PER_MIN  = 60;
    localparam int SEC_PER_HOUR = 3600;
    localparam int DAY_SECONDS  = MIN_PER_DAY * SEC_PER_MIN;
    localparam int QUIET_LEN    = QUIET_RAMP * SEC_PER_MIN;
    localparam int LEVEL_MAX    = 100;
    localparam int HOUR_MAX     = 23;
    localparam int MS_MAX       = 59;

    localparam int HOUR_W  = 5;
    localparam int MS_W    = 6;
    localparam int MIN_W   = 11;
    localparam int LEVEL_W = 7;
    localparam int SEC_W   = $clog2(DAY_SECONDS + 1);
    localparam int EL_W    = $clog2(QUIET_LEN);
    localparam int FADE_W  = LEVEL_W + EL_W + 2;

    // Restoring divider: quotient never exceeds 100
    localparam int DIV_QUO_W = LEVEL_W;
    localparam int DIV_DEN_W = SEC_W;
    localparam int DIV_REM_W = 24;
    localparam int DIV_STEPS = DIV_QUO_W;

    // stage 0, 1, 2, ramp divider, stage 10, stage 11, fade divider
    localparam int PIPE_DEPTH = 5 + 2 * DIV_STEPS;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_WAKE_ENABLE,
        REG_WAKE_START_MINUTE,
        REG_WAKE_RAMP_MINUTES,
        REG_WAKE_PEAK_LEVEL,
        REG_NIGHT_ENABLE,
        REG_NIGHT_START_MINUTE,
        REG_NIGHT_LEVEL,
        REG_BASELINE_LEVEL
    } cfg_reg_t;

    typedef logic [SEC_W-1:0]   sec_t;
    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic ramp;
        logic peak;
        logic quiet;
        logic fade;
    } sel_t;

    typedef struct packed {
        sel_t             sel;
        logic [EL_W-1:0]  el;
    } side_a_t;

    typedef struct packed {
        sel_t   sel;
        logic   neg;
        level_t day;
    } side_b_t;

    function automatic sec_t min_to_sec(input logic [MIN_W-1:0] m);
        return SEC_W'(m) * SEC_W'(SEC_PER_MIN);
    endfunction

    // Half-open window [a, b) on the day circle, empty when a == b
    function automatic logic in_window(input sec_t a, input sec_t b, input sec_t t);
        logic hit;
        if (a == b)
            hit = 1'b0;
        else if (a < b)
            hit = (t >= a) && (t < b);
        else
            hit = (t >= a) || (t < b);
        return hit;
    endfunction

    function automatic sec_t elapsed(input sec_t a, input sec_t t);
        sec_t d;
        if (t >= a)
            d = t - a;
        else
            d = SEC_W'(DAY_SECONDS) - a + t;
        return d;
    endfunction

    function automatic logic [MIN_W-1:0] sat_minute(input logic [MIN_W-1:0] v,
                                                    input logic [MIN_W-1:0] top);
        return (v > top) ? top : v;
    endfunction

    function automatic level_t sat_level(input level_t v);
        return (v > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : v;
    endfunction

endpackage

`default_nettype wire

/* design/wnbs_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module wnbs_div import wnbs_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [DIV_REM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic      [DIV_QUO_W-1:0] quo
);

    logic [DIV_REM_W-1:0] rem_reg [DIV_STEPS];
    logic [DIV_DEN_W-1:0] den_reg [DIV_STEPS];
    logic [DIV_QUO_W-1:0] quo_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DIV_REM_W-1:0] rem_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_QUO_W-1:0] quo_in;
        logic [DIV_REM_W-1:0] sub_val;
        logic                 take;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // divisor aligned to the quotient bit this stage decides
        assign sub_val = DIV_REM_W'(den_in) << (DIV_QUO_W - 1 - k);
        assign take    = rem_in >= sub_val;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? (rem_in - sub_val) : rem_in;
                den_reg[k] <= den_in;
                quo_reg[k] <= {quo_in[DIV_QUO_W-2:0], take};
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

/* design/wake_night_brightness_schedule.sv */
// Top level of the wake/night brightness schedule: config port, pipeline, output buffer.
//
//  channel   signals                                          direction
//  in        in_valid/in_ready, hour_of_day, minute_of_hour,  time sample in
//            second_of_minute
//  out       out_valid/out_ready, level_percent               brightness out
//  cfg       psel/penable/pwrite/paddr/pwdata/prdata/pready   APB registers
//
// One sample is taken per cycle while in_ready is high; each result passes through
// 5 single stages plus two 7-stage restoring dividers (ramp, fade), the first loaded at
// acceptance, then the output buffer.
// A 2-entry output buffer sits after the pipeline; in_ready depends only on its
// fill and the last stage, so a held result never blocks the pipeline at once.
// Reset restores register defaults and empties the pipeline and buffer.
`default_nettype none

module wake_night_brightness_schedule import wnbs_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [HOUR_W-1:0]   hour_of_day,
    input  wire logic [MS_W-1:0]     minute_of_hour,
    input  wire logic [MS_W-1:0]     second_of_minute,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [LEVEL_W-1:0]       level_percent,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    // ---------------- configuration registers ----------------
    logic             wake_enable_reg;
    logic [MIN_W-1:0] wake_start_minute_reg;
    logic [MIN_W-1:0] wake_ramp_minutes_reg;
    level_t           wake_peak_level_reg;
    logic             night_enable_reg;
    logic [MIN_W-1:0] night_start_minute_reg;
    level_t           night_level_reg;
    level_t           baseline_level_reg;

    logic     cfg_wr;
    cfg_reg_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_reg_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_enable_reg        <= 1'b1;
            wake_start_minute_reg  <= MIN_W'(420);
            wake_ramp_minutes_reg  <= MIN_W'(20);
            wake_peak_level_reg    <= LEVEL_W'(100);
            night_enable_reg       <= 1'b1;
            night_start_minute_reg <= MIN_W'(1320);
            night_level_reg        <= LEVEL_W'(5);
            baseline_level_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WAKE_ENABLE:        wake_enable_reg <= pwdata[0];
                REG_WAKE_START_MINUTE:  wake_start_minute_reg <=
                    sat_minute(pwdata[MIN_W-1:0], MIN_W'(MIN_PER_DAY - 1));
                REG_WAKE_RAMP_MINUTES:  wake_ramp_minutes_reg <=
                    sat_minute(pwdata[MIN_W-1:0], MIN_W'(MIN_PER_DAY));
                REG_WAKE_PEAK_LEVEL:    wake_peak_level_reg <= sat_level(pwdata[LEVEL_W-1:0]);
                REG_NIGHT_ENABLE:       night_enable_reg <= pwdata[0];
                REG_NIGHT_START_MINUTE: night_start_minute_reg <=
                    sat_minute(pwdata[MIN_W-1:0], MIN_W'(MIN_PER_DAY - 1));
                REG_NIGHT_LEVEL:        night_level_reg <= sat_level(pwdata[LEVEL_W-1:0]);
                REG_BASELINE_LEVEL:     baseline_level_reg <= sat_level(pwdata[LEVEL_W-1:0]);
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WAKE_ENABLE:        prdata = PDATA_W'(wake_enable_reg);
            REG_WAKE_START_MINUTE:  prdata = PDATA_W'(wake_start_minute_reg);
            REG_WAKE_RAMP_MINUTES:  prdata = PDATA_W'(wake_ramp_minutes_reg);
            REG_WAKE_PEAK_LEVEL:    prdata = PDATA_W'(wake_peak_level_reg);
            REG_NIGHT_ENABLE:       prdata = PDATA_W'(night_enable_reg);
            REG_NIGHT_START_MINUTE: prdata = PDATA_W'(night_start_minute_reg);
            REG_NIGHT_LEVEL:        prdata = PDATA_W'(night_level_reg);
            REG_BASELINE_LEVEL:     prdata = PDATA_W'(baseline_level_reg);
        endcase
    end

    // ---------------- derived schedule points ----------------
    // Refreshed every cycle; a sample accepted right after a write reaches
    // stage 1 no earlier than these do.
    logic [MIN_W-1:0] lead_min;
    sec_t             len_next, back_next, target_next, begin_next;
    sec_t             ns_next, ne_next, qbeg_next;
    sec_t             len_reg, half_len_reg, target_reg, begin_reg;
    sec_t             ns_reg, ne_reg, qbeg_reg;

    always_comb
    begin
        lead_min    = (wake_ramp_minutes_reg < MIN_W'(WAKE_MIN_LEAD)) ?
                      MIN_W'(WAKE_MIN_LEAD) : wake_ramp_minutes_reg;
        len_next    = min_to_sec(lead_min);
        target_next = min_to_sec(wake_start_minute_reg);
        // full-day ramp: window collapses onto the target
        back_next   = (len_next == SEC_W'(DAY_SECONDS)) ? '0 : len_next;
        if (back_next > target_next)
            begin_next = SEC_W'(DAY_SECONDS) - (back_next - target_next);
        else
            begin_next = target_next - back_next;

        ns_next = min_to_sec(night_start_minute_reg);
        ne_next = wake_enable_reg ? target_next : ns_next;
        if (SEC_W'(QUIET_LEN) > ns_next)
            qbeg_next = SEC_W'(DAY_SECONDS) - (SEC_W'(QUIET_LEN) - ns_next);
        else
            qbeg_next = ns_next - SEC_W'(QUIET_LEN);
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        half_len_reg <= len_next >> 1;
        target_reg   <= target_next;
        begin_reg    <= begin_next;
        ns_reg       <= ns_next;
        ne_reg       <= ne_next;
        qbeg_reg     <= qbeg_next;
    end

    // ---------------- pipeline control ----------------
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  adv;
    logic                  push, pop;
    logic [1:0]            count_reg;
    logic                  wr_ptr_reg, rd_ptr_reg;
    level_t                buf_reg [2];
    level_t                level_res;

    assign adv      = (count_reg != 2'd2) || !vld_reg[PIPE_DEPTH-1];
    assign in_ready = adv;
    assign push     = adv && vld_reg[PIPE_DEPTH-1];
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
    end

    // ---------------- stage 0: seconds of day ----------------
    logic [HOUR_W-1:0] h_sat;
    logic [MS_W-1:0]   m_sat, s_sat;
    sec_t              now_reg;

    always_comb
    begin
        h_sat = (hour_of_day > HOUR_W'(HOUR_MAX)) ? HOUR_W'(HOUR_MAX) : hour_of_day;
        m_sat = (minute_of_hour > MS_W'(MS_MAX)) ? MS_W'(MS_MAX) : minute_of_hour;
        s_sat = (second_of_minute > MS_W'(MS_MAX)) ? MS_W'(MS_MAX) : second_of_minute;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            now_reg <= SEC_W'(h_sat) * SEC_W'(SEC_PER_HOUR)
                     + SEC_W'(m_sat) * SEC_W'(SEC_PER_MIN) + SEC_W'(s_sat);
    end

    // ---------------- stage 1: windows ----------------
    sel_t            sel_s1;
    sec_t            since_w, since_q;
    logic            quiet_hit;
    sel_t            sel_s1_reg;
    sec_t            since_s1_reg;
    logic [EL_W-1:0] el_s1_reg;

    always_comb
    begin
        since_w   = elapsed(begin_reg, now_reg);
        since_q   = elapsed(qbeg_reg, now_reg);
        quiet_hit = (ns_reg == ne_reg) ? (now_reg >= ns_reg)
                                       : in_window(ns_reg, ne_reg, now_reg);
        sel_s1.ramp  = wake_enable_reg && in_window(begin_reg, target_reg, now_reg);
        sel_s1.peak  = wake_enable_reg && in_window(target_reg, begin_reg, now_reg);
        sel_s1.quiet = night_enable_reg && quiet_hit;
        sel_s1.fade  = night_enable_reg && !quiet_hit && in_window(qbeg_reg, ns_reg, now_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_s1_reg   <= sel_s1;
            since_s1_reg <= since_w;
            el_s1_reg    <= since_q[EL_W-1:0];    // below QUIET_LEN when fading
        end
    end

    // ---------------- stage 2: ramp numerator ----------------
    logic [DIV_REM_W-1:0] numa_reg;
    side_a_t              side_s2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numa_reg <= DIV_REM_W'(wake_peak_level_reg) * DIV_REM_W'(since_s1_reg)
                      + DIV_REM_W'(half_len_reg);
            side_s2_reg.sel <= sel_s1_reg;
            side_s2_reg.el  <= el_s1_reg;
        end
    end

    // ---------------- ramp divider ----------------
    logic [DIV_QUO_W-1:0] quo_a;
    side_a_t              side_a_reg [DIV_STEPS];

    wnbs_div u_div_ramp (
        .clk (clk),
        .en  (adv),
        .num (numa_reg),
        .den (len_reg),
        .quo (quo_a)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_a_reg[0] <= side_s2_reg;
            for (int k = 1; k < DIV_STEPS; k++)
                side_a_reg[k] <= side_a_reg[k-1];
        end
    end

    // ---------------- stage 10: day level ----------------
    side_a_t side_a_last;
    level_t  day_next;
    level_t  day_s10_reg;
    side_a_t side_s10_reg;

    assign side_a_last = side_a_reg[DIV_STEPS-1];

    always_comb
    begin
        if (side_a_last.sel.ramp)
            day_next = (quo_a < baseline_level_reg) ? baseline_level_reg : quo_a;
        else if (side_a_last.sel.peak)
            day_next = wake_peak_level_reg;
        else
            day_next = baseline_level_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            day_s10_reg  <= day_next;
            side_s10_reg <= side_a_last;
        end
    end

    // ---------------- stage 11: fade numerator, sign and magnitude ----------------
    logic signed [LEVEL_W:0]  diff;
    logic signed [FADE_W-1:0] fprod, fnum;
    logic        [FADE_W-1:0] fmag;
    logic [DIV_REM_W-1:0]     numb_reg;
    side_b_t                  side_s11_reg;

    always_comb
    begin
        diff  = $signed({1'b0, night_level_reg}) - $signed({1'b0, day_s10_reg});
        fprod = FADE_W'(diff) * FADE_W'($signed({1'b0, side_s10_reg.el}));
        fnum  = fprod + FADE_W'(QUIET_LEN / 2);
        // truncation toward zero: divide the magnitude, restore the sign later
        fmag  = fnum[FADE_W-1] ? FADE_W'(-fnum) : FADE_W'(fnum);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numb_reg         <= DIV_REM_W'(fmag);
            side_s11_reg.sel <= side_s10_reg.sel;
            side_s11_reg.neg <= fnum[FADE_W-1];
            side_s11_reg.day <= day_s10_reg;
        end
    end

    // ---------------- fade divider ----------------
    logic [DIV_QUO_W-1:0] quo_b;
    side_b_t              side_b_reg [DIV_STEPS];
    side_b_t              side_b_last;

    wnbs_div u_div_fade (
        .clk (clk),
        .en  (adv),
        .num (numb_reg),
        .den (DIV_DEN_W'(QUIET_LEN)),
        .quo (quo_b)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_b_reg[0] <= side_s11_reg;
            for (int k = 1; k < DIV_STEPS; k++)
                side_b_reg[k] <= side_b_reg[k-1];
        end
    end

    assign side_b_last = side_b_reg[DIV_STEPS-1];

    // ---------------- final select ----------------
    logic signed [LEVEL_W+1:0] fq, fres;
    level_t                    fade_lvl;

    always_comb
    begin
        fq   = $signed({2'b00, quo_b});
        fres = $signed({2'b00, side_b_last.day}) + (side_b_last.neg ? -fq : fq);
        if (fres < 0)
            fade_lvl = '0;
        else if (fres > (LEVEL_W+2)'(LEVEL_MAX))
            fade_lvl = LEVEL_W'(LEVEL_MAX);
        else
            fade_lvl = fres[LEVEL_W-1:0];

        if (side_b_last.sel.quiet)
            level_res = night_level_reg;
        else if (side_b_last.sel.fade)
            level_res = fade_lvl;
        else
            level_res = side_b_last.day;
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= level_res;
    end

    assign out_valid     = count_reg != 2'd0;
    assign level_percent = buf_reg[rd_ptr_reg];

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the wake/night brightness schedule block.
`default_nettype none

module tb_top import wnbs_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    logic                clk;
    logic                rst_n            = 1'b0;
    logic                in_valid         = 1'b0;
    logic                in_ready;
    logic [HOUR_W-1:0]   hour_of_day      = '0;
    logic [MS_W-1:0]     minute_of_hour   = '0;
    logic [MS_W-1:0]     second_of_minute = '0;
    logic                out_valid;
    logic                out_ready        = 1'b0;
    logic [LEVEL_W-1:0]  level_percent;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [PADDR_W-1:0]  paddr            = '0;
    logic [PDATA_W-1:0]  pwdata           = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Register mirror, held in saturated form
    typedef struct {
        bit          wake_en;
        int unsigned wake_start;
        int unsigned wake_ramp;
        int unsigned wake_peak;
        bit          night_en;
        int unsigned night_start;
        int unsigned night_lvl;
        int unsigned base_lvl;
    } sched_cfg_t;

    sched_cfg_t          sched;
    logic [LEVEL_W-1:0]  level_q[$];
    int                  err_count = 0;
    bit                  steady    = 1'b0;

    wake_night_brightness_schedule u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .level_percent    (level_percent),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic int unsigned back_in_day(input int unsigned t, input int unsigned back);
        int unsigned b;
        b = back % DAY_SECONDS;
        return (b > t) ? DAY_SECONDS - (b - t) : t - b;
    endfunction

    // [a, b) on the day circle, empty when a == b
    function automatic bit on_arc(input int unsigned a, input int unsigned b,
                                  input int unsigned t);
        bit hit;
        if (a == b)
            hit = 1'b0;
        else if (a < b)
            hit = (t >= a) && (t < b);
        else
            hit = (t >= a) || (t < b);
        return hit;
    endfunction

    function automatic int unsigned secs_from(input int unsigned a, input int unsigned t);
        return (t >= a) ? t - a : DAY_SECONDS - a + t;
    endfunction

    function automatic int unsigned sched_level(input logic [HOUR_W-1:0] hr,
                                                input logic [MS_W-1:0] mn,
                                                input logic [MS_W-1:0] sc);
        int unsigned h, m, s, now, lvl, day_lvl;
        int unsigned target, lead, len, ramp_beg, r;
        int unsigned ns, ne, qlen, qbeg, el;
        bit          quiet;
        int          diff, el_i, qlen_i, faded;
        h   = (hr > HOUR_MAX) ? HOUR_MAX : hr;
        m   = (mn > MS_MAX) ? MS_MAX : mn;
        s   = (sc > MS_MAX) ? MS_MAX : sc;
        now = h * 3600 + m * 60 + s;
        lvl = sched.base_lvl;
        if (sched.wake_en)
        begin
            target   = sched.wake_start * 60;
            lead     = (sched.wake_ramp < WAKE_MIN_LEAD) ? WAKE_MIN_LEAD : sched.wake_ramp;
            len      = lead * 60;
            ramp_beg = back_in_day(target, len);
            if (on_arc(ramp_beg, target, now))
            begin
                r   = (sched.wake_peak * secs_from(ramp_beg, now) + len / 2) / len;
                lvl = (r < sched.base_lvl) ? sched.base_lvl : r;
            end
            else if (on_arc(target, ramp_beg, now))
                lvl = sched.wake_peak;
        end
        day_lvl = lvl;
        if (sched.night_en)
        begin
            ns    = sched.night_start * 60;
            ne    = sched.wake_en ? sched.wake_start * 60 : ns;
            qlen  = QUIET_RAMP * 60;
            qbeg  = back_in_day(ns, qlen);
            quiet = (ns == ne) ? (now >= ns) : on_arc(ns, ne, now);
            if (quiet)
                lvl = sched.night_lvl;
            else if (on_arc(qbeg, ns, now))
            begin
                el     = secs_from(qbeg, now);
                el_i   = (el > qlen) ? qlen : el;
                qlen_i = qlen;
                diff   = int'(sched.night_lvl) - int'(day_lvl);
                // signed division, truncates toward zero
                faded  = int'(day_lvl) + (diff * el_i + qlen_i / 2) / qlen_i;
                if (faded < 0)
                    faded = 0;
                else if (faded > LEVEL_MAX)
                    faded = LEVEL_MAX;
                lvl = faded;
            end
        end
        return (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        $display("tb_top mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (level_q.size() == 0)
                report_mismatch($sformatf("level_percent %0d with no pending transaction",
                                          level_percent));
            else
            begin
                if (level_percent !== level_q[0])
                    report_mismatch($sformatf("level_percent %0d, expected %0d",
                                              level_percent, level_q[0]));
                void'(level_q.pop_front());
            end
        end
        out_ready <= steady || ($urandom_range(99) >= 25);
    end

    // ---------------------------------------------------------------- driving

    task automatic send_time(input logic [HOUR_W-1:0] h, input logic [MS_W-1:0] m,
                             input logic [MS_W-1:0] s);
        int gap;
        gap = (steady || $urandom_range(99) >= 25) ? 0 : $urandom_range(1, 2);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        hour_of_day      <= h;
        minute_of_hour   <= m;
        second_of_minute <= s;
        do @(posedge clk); while (!in_ready);
        level_q.push_back(LEVEL_W'(sched_level(h, m, s)));
    endtask

    // Stop sending and wait until every expected result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (level_q.size() != 0);
    endtask

    task automatic apb_write(input cfg_reg_t idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WAKE_ENABLE:        sched.wake_en     = val[0];
            REG_WAKE_START_MINUTE:  sched.wake_start  = (val[10:0] > 1439) ? 1439 : val[10:0];
            REG_WAKE_RAMP_MINUTES:  sched.wake_ramp   = (val[10:0] > 1440) ? 1440 : val[10:0];
            REG_WAKE_PEAK_LEVEL:    sched.wake_peak   = (val[6:0] > 100) ? 100 : val[6:0];
            REG_NIGHT_ENABLE:       sched.night_en    = val[0];
            REG_NIGHT_START_MINUTE: sched.night_start = (val[10:0] > 1439) ? 1439 : val[10:0];
            REG_NIGHT_LEVEL:        sched.night_lvl   = (val[6:0] > 100) ? 100 : val[6:0];
            REG_BASELINE_LEVEL:     sched.base_lvl    = (val[6:0] > 100) ? 100 : val[6:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_schedule(input logic [PDATA_W-1:0] wake_en, wake_start,
                                    wake_ramp, wake_peak, night_en, night_start,
                                    night_lvl, base_lvl);
        drain_results();
        apb_write(REG_WAKE_ENABLE, wake_en);
        apb_write(REG_WAKE_START_MINUTE, wake_start);
        apb_write(REG_WAKE_RAMP_MINUTES, wake_ramp);
        apb_write(REG_WAKE_PEAK_LEVEL, wake_peak);
        apb_write(REG_NIGHT_ENABLE, night_en);
        apb_write(REG_NIGHT_START_MINUTE, night_start);
        apb_write(REG_NIGHT_LEVEL, night_lvl);
        apb_write(REG_BASELINE_LEVEL, base_lvl);
    endtask

    // ---------------------------------------------------------------- random helpers

    function automatic logic [PDATA_W-1:0] rand_reg(input cfg_reg_t idx);
        logic [PDATA_W-1:0] v;
        if ($urandom_range(99) < 15)
            v = $urandom;               // raw bits, exercises saturation
        else
            case (idx)
                REG_WAKE_ENABLE, REG_NIGHT_ENABLE:
                    v = ($urandom_range(3) != 0) ? 1 : 0;
                REG_WAKE_START_MINUTE, REG_NIGHT_START_MINUTE:
                    v = $urandom_range(0, 1439);
                REG_WAKE_RAMP_MINUTES:
                    v = ($urandom_range(3) == 0) ? $urandom_range(0, 1440)
                                                 : $urandom_range(0, 90);
                default:
                    v = $urandom_range(0, 100);
            endcase
        return v;
    endfunction

    // Mostly times near the wake and night edges, where ramp and fade live
    function automatic void pick_time(output logic [HOUR_W-1:0] h, output logic [MS_W-1:0] m,
                                      output logic [MS_W-1:0] s);
        int unsigned t, anchor, sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            h = HOUR_W'($urandom);
            m = MS_W'($urandom);
            s = MS_W'($urandom);
        end
        else
        begin
            if (sel <= 3)
                anchor = sched.wake_start * 60;
            else if (sel <= 6)
                anchor = sched.night_start * 60;
            else
                anchor = $urandom_range(0, DAY_SECONDS - 1);
            t = (anchor + DAY_SECONDS + $urandom_range(0, 14400) - 7200) % DAY_SECONDS;
            h = HOUR_W'(t / 3600);
            m = MS_W'((t / 60) % 60);
            s = MS_W'(t % 60);
        end
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_default_schedule();
        send_time(0, 0, 0);
        send_time(23, 59, 59);
        send_time(31, 63, 63);      // all fields above range
        send_time(24, 60, 60);
        send_time(6, 30, 0);        // ramp start: lead raised to the minimum
        send_time(6, 44, 59);
        send_time(6, 59, 59);
        send_time(7, 0, 0);         // peak
        send_time(12, 0, 0);
        send_time(20, 30, 0);       // fade start
        send_time(21, 14, 30);
        send_time(21, 59, 59);
        send_time(22, 0, 0);        // quiet hours
    endtask

    task automatic test_register_extremes();
        // everything off: baseline only
        program_schedule(0, 0, 0, 0, 0, 0, 0, 0);
        send_time(0, 0, 0);
        send_time(12, 0, 0);
        // all ones: full-day ramp, night start equal to wake start
        program_schedule('1, '1, '1, '1, '1, '1, '1, '1);
        send_time(23, 59, 0);
        send_time(23, 58, 59);
        // ramp wraps midnight, peak below the baseline floor
        program_schedule(1, 10, 0, 40, 1, 10, 90, 60);
        send_time(23, 45, 0);
        send_time(0, 5, 0);
        send_time(0, 10, 0);
        // wake off: quiet hours run to midnight only
        program_schedule(0, 420, 20, 100, 1, 1320, 0, 100);
        send_time(23, 0, 0);
        send_time(1, 0, 0);
        send_time(21, 0, 0);
    endtask

    task automatic test_random_schedules();
        logic [HOUR_W-1:0] h;
        logic [MS_W-1:0]   m, s;
        for (int phase = 0; phase < 10; phase++)
        begin
            program_schedule(rand_reg(REG_WAKE_ENABLE), rand_reg(REG_WAKE_START_MINUTE),
                             rand_reg(REG_WAKE_RAMP_MINUTES), rand_reg(REG_WAKE_PEAK_LEVEL),
                             rand_reg(REG_NIGHT_ENABLE), rand_reg(REG_NIGHT_START_MINUTE),
                             rand_reg(REG_NIGHT_LEVEL), rand_reg(REG_BASELINE_LEVEL));
            steady = (phase == 4);
            for (int i = 0; i < 90; i++)
            begin
                if (phase == 6 && i == 45)
                    drain_results();
                pick_time(h, m, s);
                send_time(h, m, s);
            end
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        sched = '{wake_en: 1'b1, wake_start: 420, wake_ramp: 20, wake_peak: 100,
                  night_en: 1'b1, night_start: 1320, night_lvl: 5, base_lvl: 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_schedule();
        test_register_extremes();
        test_random_schedules();

        drain_results();
        repeat (30) @(posedge clk);
        if (level_q.size() != 0)
            report_mismatch("transactions still awaiting results");

        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/wnbs_pkg.sv
design/wnbs_div.sv
design/wake_night_brightness_schedule.sv
tb/tb_top.sv
